/* rtl/core/dvlbv_pkg.sv */
// Shared types, constants and fixed-point helpers for the DVL body-velocity block.
package dvlbv_pkg;

	// Fixed-point formats and datapath widths.
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int TIME_W    = 48;
	localparam int QUAT_W    = 16;
	localparam int MUL_W     = 34;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int ACC_W     = 66;
	localparam int NUM_W     = 53;
	localparam int QUO_W     = 32;
	localparam int RQ_W      = 27;
	localparam int R28_W     = 35;
	localparam int ROT_FRAC  = 20;
	localparam int ROT_PRE   = 8;
	localparam int CFG_AW    = 6;
	localparam int CFG_DW    = 64;

	localparam logic signed [MUL_W-1:0] VEL_SCALE = MUL_W'(1000000);
	localparam logic signed [DATA_W-1:0] S32_MAX  = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] S32_MIN  = 32'sh8000_0000;

	// Configuration register map, one 64-bit slot per register.
	typedef enum logic [2:0] {
		REG_DECIMATION,
		REG_MAX_DEPTH,
		REG_MAX_LOCK,
		REG_LEVER_X,
		REG_LEVER_Y,
		REG_LEVER_Z,
		REG_MOUNT_QUAT
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VMUL,
		ST_VDIV,
		ST_QPROD,
		ST_ROT,
		ST_RFIN,
		ST_ARM,
		ST_AFIN,
		ST_ASUM,
		ST_FIN
	} state_t;

	// Which quaternion the rotation phase is working on.
	typedef enum logic {
		SRC_ATT,
		SRC_MOUNT
	} src_t;

	// Divider status towards the sequencer.
	typedef struct packed {
		logic done;
		logic ovf;
	} div_sts_t;

	// Quaternion component products, in the order they are formed.
	localparam int QP_XX = 0;
	localparam int QP_YY = 1;
	localparam int QP_ZZ = 2;
	localparam int QP_XY = 3;
	localparam int QP_XZ = 4;
	localparam int QP_YZ = 5;
	localparam int QP_WX = 6;
	localparam int QP_WY = 7;
	localparam int QP_WZ = 8;
	localparam int QP_N  = 9;

	// Component selects (w=0, x=1, y=2, z=3) for each product.
	localparam logic [1:0] QP_A [QP_N] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};
	localparam logic [1:0] QP_B [QP_N] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3};

	// Lever-arm cross product terms: rate (p,q,r) times lever (x,y,z).
	localparam logic [1:0] ARM_RATE  [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
	localparam logic [1:0] ARM_LEVER [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){x[DATA_W-1]}}) begin
			r = x[DATA_W-1:0];
		end else begin
			r = x[ACC_W-1] ? S32_MIN : S32_MAX;
		end
		return r;
	endfunction

	// Round half up and shift right arithmetically by k bits.
	function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] x,
			input int k);
		logic signed [ACC_W-1:0] t;
		t = x + (ACC_W'(1) <<< (k - 1));
		return t >>> k;
	endfunction

endpackage

/* rtl/core/dvl_body_velocity_from_pose_top.sv */
// Top level of the DVL emulator: velocity from pose samples, rotated into the sensor frame.
// A non-emitting sample only advances the decimation counter and leaves the input unstalled.
// An emitting sample goes through the whole sequence. Each of the three NED components needs
// one multiply and a 32-step bit-serial division; the division is cut short when the quotient
// overflows and left out when the elapsed time is zero. A single 34x34 multiplier then forms
// the quaternion products, the two matrix-vector rotations and the lever-arm cross product,
// followed by the rounding and summing steps and the final hand-over. Input stall is high for
// the whole of that time; the finished result sits in an output register, so the next
// transaction is taken while it waits, and a later result only waits if the earlier one has
// still not been taken.
module dvl_body_velocity_from_pose_top import dvlbv_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_AW-1:0]         paddr,
	input  logic [CFG_DW-1:0]         pwdata,
	output logic [CFG_DW-1:0]         prdata,
	output logic                      pready,
	// pose input
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [TIME_W-1:0]         time_us,
	input  logic signed [DATA_W-1:0]  pos_x,
	input  logic signed [DATA_W-1:0]  pos_y,
	input  logic signed [DATA_W-1:0]  pos_z,
	input  logic signed [QUAT_W-1:0]  att_w,
	input  logic signed [QUAT_W-1:0]  att_x,
	input  logic signed [QUAT_W-1:0]  att_y,
	input  logic signed [QUAT_W-1:0]  att_z,
	input  logic signed [DATA_W-1:0]  rate_p,
	input  logic signed [DATA_W-1:0]  rate_q,
	input  logic signed [DATA_W-1:0]  rate_r,
	// velocity output
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  ned_vx,
	output logic signed [DATA_W-1:0]  ned_vy,
	output logic signed [DATA_W-1:0]  ned_vz,
	output logic signed [DATA_W-1:0]  body_u,
	output logic signed [DATA_W-1:0]  body_v,
	output logic signed [DATA_W-1:0]  body_w,
	output logic signed [DATA_W-1:0]  altitude,
	output logic                      bottom_lock
);

	localparam logic signed [R28_W-1:0] Q28_ONE = R28_W'(1) <<< 28;

	// Configuration registers.
	logic [7:0]                decimation_q;
	logic [30:0]               max_depth_q;
	logic [30:0]               max_lock_q;
	logic signed [DATA_W-1:0]  lever_q [3];
	logic [63:0]               mount_q;

	// Item state.
	logic [7:0]                cnt_q;
	logic [TIME_W-1:0]         last_time_q;
	logic signed [DATA_W-1:0]  last_pos_q [3];

	// Sequencer.
	state_t                    state_q, state_d;
	logic                      half_q;
	logic [3:0]                idx_q;
	logic [1:0]                ri_q;
	logic [1:0]                rj_q;
	src_t                      src_q;

	// Working registers.
	logic [TIME_W-1:0]         dt_q;
	logic signed [DATA_W:0]    d_q [3];
	logic signed [QUAT_W-1:0]  att_q [4];
	logic signed [DATA_W-1:0]  rates_q [3];
	logic signed [DATA_W-1:0]  alt_q;
	logic                      lock_q;
	logic signed [DATA_W-1:0]  vel_q [3];
	logic signed [DATA_W-1:0]  body_q [3];
	logic signed [DATA_W-1:0]  sens_q [3];
	logic signed [DATA_W-1:0]  qp_q [QP_N];
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [DATA_W-1:0]  arm_q;

	// Output register.
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  o_vel_q [3];
	logic signed [DATA_W-1:0]  o_sens_q [3];
	logic signed [DATA_W-1:0]  o_alt_q;
	logic                      o_lock_q;

	// Combinational signals.
	logic                      cfg_wr;
	logic [7:0]                dec_eff;
	logic [8:0]                cnt_next;
	logic                      emit;
	logic                      in_acc;
	logic                      out_free;
	logic                      dt_zero;
	logic [1:0]                comp;
	logic signed [DATA_W:0]    d_cur;
	logic [DATA_W:0]           d_abs;
	logic signed [DATA_W:0]    alt33;
	logic signed [QUAT_W-1:0]  qsrc [4];
	logic signed [R28_W-1:0]   r28 [3][3];
	logic signed [RQ_W-1:0]    rq [3][3];
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic                      div_start;
	logic [NUM_W-1:0]          div_num;
	logic [QUO_W-1:0]          div_quo;
	div_sts_t                  div_sts;
	logic signed [DATA_W-1:0]  vdiv;
	logic signed [DATA_W-1:0]  vzero;
	logic                      vsat;
	logic signed [DATA_W-1:0]  rfin_res;

	// Configuration port decode.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (reg_idx_t'(paddr[5:3]))
			REG_DECIMATION: prdata = CFG_DW'(decimation_q);
			REG_MAX_DEPTH:  prdata = CFG_DW'(max_depth_q);
			REG_MAX_LOCK:   prdata = CFG_DW'(max_lock_q);
			REG_LEVER_X:    prdata = CFG_DW'(unsigned'(lever_q[0]));
			REG_LEVER_Y:    prdata = CFG_DW'(unsigned'(lever_q[1]));
			REG_LEVER_Z:    prdata = CFG_DW'(unsigned'(lever_q[2]));
			REG_MOUNT_QUAT: prdata = mount_q;
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decimation_q <= 8'd1;
			max_depth_q  <= 31'd6553600;
			max_lock_q   <= 31'd6553600;
			lever_q[0]   <= '0;
			lever_q[1]   <= '0;
			lever_q[2]   <= '0;
			mount_q      <= 64'h4000_0000_0000_0000;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[5:3]))
				REG_DECIMATION: decimation_q <= pwdata[7:0];
				REG_MAX_DEPTH:  max_depth_q  <= pwdata[30:0];
				REG_MAX_LOCK:   max_lock_q   <= pwdata[30:0];
				REG_LEVER_X:    lever_q[0]   <= signed'(pwdata[31:0]);
				REG_LEVER_Y:    lever_q[1]   <= signed'(pwdata[31:0]);
				REG_LEVER_Z:    lever_q[2]   <= signed'(pwdata[31:0]);
				REG_MOUNT_QUAT: mount_q      <= pwdata;
				default:        ;
			endcase
		end
	end

	// Decimation: a sample emits when the incremented count reaches the divider.
	assign dec_eff  = (decimation_q == 8'd0) ? 8'd1 : decimation_q;
	assign cnt_next = {1'b0, cnt_q} + 9'd1;
	assign emit     = cnt_next >= {1'b0, dec_eff};
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	// Altitude above the seafloor at the accepted sample.
	assign alt33 = signed'({2'b00, max_depth_q}) - (DATA_W+1)'(pos_z);

	// Velocity helpers for the component in hand.
	assign dt_zero = (dt_q == '0);
	assign comp    = idx_q[1:0];
	assign d_cur   = d_q[comp];
	assign d_abs   = d_cur[DATA_W] ? unsigned'(-d_cur) : unsigned'(d_cur);
	assign vsat    = div_sts.ovf | div_quo[QUO_W-1];
	assign vdiv    = d_cur[DATA_W] ? (vsat ? S32_MIN : -signed'(div_quo))
	                               : (vsat ? S32_MAX : signed'(div_quo));
	assign vzero   = d_cur[DATA_W] ? S32_MIN : ((d_cur == '0) ? '0 : S32_MAX);
	assign div_num = prod_q[NUM_W-1:0] + NUM_W'(dt_q >> 1);

	// Quaternion under rotation.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			qsrc[k] = (src_q == SRC_MOUNT) ? signed'(mount_q[63 - 16*k -: 16]) : att_q[k];
		end
	end

	// Rotation matrix in Q28 from the stored products, rounded to Q20.
	always_comb begin
		r28[0][0] = Q28_ONE - 2 * (R28_W'(qp_q[QP_YY]) + R28_W'(qp_q[QP_ZZ]));
		r28[0][1] = 2 * (R28_W'(qp_q[QP_XY]) - R28_W'(qp_q[QP_WZ]));
		r28[0][2] = 2 * (R28_W'(qp_q[QP_XZ]) + R28_W'(qp_q[QP_WY]));
		r28[1][0] = 2 * (R28_W'(qp_q[QP_XY]) + R28_W'(qp_q[QP_WZ]));
		r28[1][1] = Q28_ONE - 2 * (R28_W'(qp_q[QP_XX]) + R28_W'(qp_q[QP_ZZ]));
		r28[1][2] = 2 * (R28_W'(qp_q[QP_YZ]) - R28_W'(qp_q[QP_WX]));
		r28[2][0] = 2 * (R28_W'(qp_q[QP_XZ]) - R28_W'(qp_q[QP_WY]));
		r28[2][1] = 2 * (R28_W'(qp_q[QP_YZ]) + R28_W'(qp_q[QP_WX]));
		r28[2][2] = Q28_ONE - 2 * (R28_W'(qp_q[QP_XX]) + R28_W'(qp_q[QP_YY]));
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				rq[j][i] = RQ_W'((r28[j][i] + R28_W'(128)) >>> ROT_PRE);
			end
		end
	end

	assign rfin_res = sat32(rnd_shift(acc_q, ROT_FRAC));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc && emit) state_d = ST_VMUL;
			ST_VMUL: begin
				if (dt_zero) begin
					state_d = (comp == 2'd2) ? ST_QPROD : ST_VMUL;
				end else if (half_q) begin
					state_d = ST_VDIV;
				end
			end
			ST_VDIV:  if (div_sts.done) state_d = (comp == 2'd2) ? ST_QPROD : ST_VMUL;
			ST_QPROD: if (half_q && idx_q == 4'(QP_N - 1)) state_d = ST_ROT;
			ST_ROT:   if (half_q && rj_q == 2'd2) state_d = ST_RFIN;
			ST_RFIN: begin
				if (ri_q == 2'd2) begin
					state_d = (src_q == SRC_ATT) ? ST_ARM : ST_FIN;
				end else begin
					state_d = ST_ROT;
				end
			end
			ST_ARM:   if (half_q && idx_q[0]) state_d = ST_AFIN;
			ST_AFIN:  state_d = ST_ASUM;
			ST_ASUM:  state_d = (idx_q[2:1] == 2'd2) ? ST_QPROD : ST_ARM;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Output decode: stall, divider start and multiplier operand selection.
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_VMUL: begin
				mul_a     = MUL_W'(d_abs);
				mul_b     = VEL_SCALE;
				div_start = half_q & ~dt_zero;
			end
			ST_QPROD: begin
				mul_a = MUL_W'(qsrc[QP_A[idx_q]]);
				mul_b = MUL_W'(qsrc[QP_B[idx_q]]);
			end
			ST_ROT: begin
				mul_a = MUL_W'(rq[rj_q][ri_q]);
				mul_b = (src_q == SRC_MOUNT) ? MUL_W'(body_q[rj_q]) : MUL_W'(vel_q[rj_q]);
			end
			ST_ARM: begin
				mul_a = MUL_W'(rates_q[ARM_RATE[idx_q[2:0]]]);
				mul_b = MUL_W'(lever_q[ARM_LEVER[idx_q[2:0]]]);
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	dvlbv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (dt_q),
		.quo    (div_quo),
		.sts    (div_sts)
	);

	// Control state, item state and sequencer counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			half_q        <= 1'b0;
			idx_q         <= '0;
			ri_q          <= '0;
			rj_q          <= '0;
			src_q         <= SRC_ATT;
			cnt_q         <= '0;
			last_time_q   <= '0;
			last_pos_q[0] <= '0;
			last_pos_q[1] <= '0;
			last_pos_q[2] <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			half_q  <= 1'b0;
			if (in_acc) begin
				cnt_q <= emit ? 8'd0 : cnt_next[7:0];
				if (emit) begin
					last_time_q   <= time_us;
					last_pos_q[0] <= pos_x;
					last_pos_q[1] <= pos_y;
					last_pos_q[2] <= pos_z;
					idx_q         <= '0;
					src_q         <= SRC_ATT;
				end
			end
			case (state_q)
				ST_VMUL: begin
					if (dt_zero) begin
						idx_q <= (comp == 2'd2) ? 4'd0 : idx_q + 4'd1;
					end else begin
						half_q <= ~half_q;
					end
				end
				ST_VDIV: begin
					if (div_sts.done) idx_q <= (comp == 2'd2) ? 4'd0 : idx_q + 4'd1;
				end
				ST_QPROD: begin
					half_q <= ~half_q;
					if (half_q) begin
						if (idx_q == 4'(QP_N - 1)) begin
							idx_q <= '0;
							ri_q  <= '0;
							rj_q  <= '0;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				ST_ROT: begin
					half_q <= ~half_q;
					if (half_q && rj_q != 2'd2) rj_q <= rj_q + 2'd1;
				end
				ST_RFIN: begin
					rj_q <= '0;
					ri_q <= (ri_q == 2'd2) ? 2'd0 : ri_q + 2'd1;
				end
				ST_ARM: begin
					half_q <= ~half_q;
					if (half_q && !idx_q[0]) idx_q <= idx_q + 4'd1;
				end
				ST_ASUM: begin
					if (idx_q[2:1] == 2'd2) begin
						idx_q <= '0;
						src_q <= SRC_MOUNT;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				default: ;
			endcase
			// Output register handshake.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			dt_q       <= time_us - last_time_q;
			d_q[0]     <= (DATA_W+1)'(pos_x) - (DATA_W+1)'(last_pos_q[0]);
			d_q[1]     <= (DATA_W+1)'(pos_y) - (DATA_W+1)'(last_pos_q[1]);
			d_q[2]     <= (DATA_W+1)'(pos_z) - (DATA_W+1)'(last_pos_q[2]);
			att_q[0]   <= att_w;
			att_q[1]   <= att_x;
			att_q[2]   <= att_y;
			att_q[3]   <= att_z;
			rates_q[0] <= rate_p;
			rates_q[1] <= rate_q;
			rates_q[2] <= rate_r;
			lock_q     <= alt33 < signed'({2'b00, max_lock_q});
			alt_q      <= (alt33 < signed'({2'b00, max_lock_q})) ? alt33[DATA_W-1:0] : '0;
		end
		prod_q <= mul_p;
		case (state_q)
			ST_VMUL:  if (dt_zero) vel_q[comp] <= vzero;
			ST_VDIV:  if (div_sts.done) vel_q[comp] <= vdiv;
			ST_QPROD: if (half_q) qp_q[idx_q] <= prod_q[DATA_W-1:0];
			ST_ROT: begin
				if (half_q) acc_q <= ((rj_q == 2'd0) ? '0 : acc_q) + ACC_W'(prod_q);
			end
			ST_RFIN: begin
				if (src_q == SRC_ATT) begin
					body_q[ri_q] <= rfin_res;
				end else begin
					sens_q[ri_q] <= rfin_res;
				end
			end
			ST_ARM: begin
				if (half_q) acc_q <= idx_q[0] ? acc_q - ACC_W'(prod_q) : ACC_W'(prod_q);
			end
			ST_AFIN:  arm_q <= sat32(rnd_shift(acc_q, FRAC_BITS));
			ST_ASUM:  body_q[idx_q[2:1]] <= sat32(ACC_W'(body_q[idx_q[2:1]]) + ACC_W'(arm_q));
			default: ;
		endcase
		if (state_q == ST_FIN && out_free) begin
			for (int k = 0; k < 3; k++) begin
				o_vel_q[k]  <= vel_q[k];
				o_sens_q[k] <= sens_q[k];
			end
			o_alt_q  <= alt_q;
			o_lock_q <= lock_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign ned_vx      = o_vel_q[0];
	assign ned_vy      = o_vel_q[1];
	assign ned_vz      = o_vel_q[2];
	assign body_u      = o_sens_q[0];
	assign body_v      = o_sens_q[1];
	assign body_w      = o_sens_q[2];
	assign altitude    = o_alt_q;
	assign bottom_lock = o_lock_q;

endmodule

/* rtl/core/dvlbv_div.sv */
// Bit-serial restoring divider for the velocity quotient, one quotient bit per cycle.
module dvlbv_div import dvlbv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [TIME_W-1:0]  den,
	output logic [QUO_W-1:0]   quo,
	output div_sts_t           sts
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic                ovf_q;
	logic [TIME_W-1:0]   rem_q;
	logic [QUO_W-1:0]    lo_q;
	logic [NUM_W-QUO_W-1:0] hi;
	logic                ovf_start;
	logic [TIME_W:0]     trial;
	logic [TIME_W:0]     diff;
	logic                ge;

	// The quotient overflows 32 bits exactly when the upper numerator part reaches the divisor.
	assign hi        = num[NUM_W-1:QUO_W];
	assign ovf_start = TIME_W'(hi) >= den;

	// One restoring step.
	assign trial = {rem_q, lo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = trial >= {1'b0, den};

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (ovf_start) begin
					done_q <= 1'b1;
					ovf_q  <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(QUO_W);
					ovf_q  <= 1'b0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= TIME_W'(hi);
			lo_q  <= num[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
			lo_q  <= {lo_q[QUO_W-2:0], ge};
		end
	end

	assign quo      = lo_q;
	assign sts.done = done_q;
	assign sts.ovf  = ovf_q;

endmodule

/* rtl/core/dvlbv_checker.sv */
// Port-level checks for the DVL body-velocity block, bound to its top level.
module dvlbv_checker import dvlbv_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [DATA_W-1:0]  ned_vx,
	input logic signed [DATA_W-1:0]  altitude,
	input logic                      bottom_lock
);

	// A stalled result transaction stays valid and keeps its ned_vx and altitude payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ned_vx) && $stable(altitude))
		else $error("stalled result changed");

	// Without bottom lock the altitude reads zero.
	a_alt_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bottom_lock |-> altitude == '0)
		else $error("altitude reported without bottom lock");

	// A new result only appears at the end of a busy period.
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without computation");

	// The block only goes busy after taking an input transaction.
	a_busy_after_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stall raised without an input transaction");

endmodule

bind dvl_body_velocity_from_pose_top dvlbv_checker u_dvlbv_checker (.*);

/* dv/dvl_body_velocity_checker.sv */
`timescale 1ns / 100ps
// Checker for the pose-to-velocity block: predicts every result and compares it with the output.
module dvl_body_velocity_checker import dvlbv_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic                      pready,
	input  logic [CFG_AW-1:0]         paddr,
	input  logic [CFG_DW-1:0]         pwdata,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [TIME_W-1:0]         time_us,
	input  logic signed [DATA_W-1:0]  pos_x,
	input  logic signed [DATA_W-1:0]  pos_y,
	input  logic signed [DATA_W-1:0]  pos_z,
	input  logic signed [QUAT_W-1:0]  att_w,
	input  logic signed [QUAT_W-1:0]  att_x,
	input  logic signed [QUAT_W-1:0]  att_y,
	input  logic signed [QUAT_W-1:0]  att_z,
	input  logic signed [DATA_W-1:0]  rate_p,
	input  logic signed [DATA_W-1:0]  rate_q,
	input  logic signed [DATA_W-1:0]  rate_r,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [DATA_W-1:0]  ned_vx,
	input  logic signed [DATA_W-1:0]  ned_vy,
	input  logic signed [DATA_W-1:0]  ned_vz,
	input  logic signed [DATA_W-1:0]  body_u,
	input  logic signed [DATA_W-1:0]  body_v,
	input  logic signed [DATA_W-1:0]  body_w,
	input  logic signed [DATA_W-1:0]  altitude,
	input  logic                      bottom_lock,
	output int                        fail_count,
	output int                        pending
);

	typedef logic signed [79:0] wide_t;

	typedef struct packed {
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic [31:0] bu;
		logic [31:0] bv;
		logic [31:0] bw;
		logic [31:0] alt;
		logic        lock;
	} velocity_t;

	velocity_t   velocity_q[$];

	// Shadow of the configuration registers.
	logic [7:0]  decim;
	logic [30:0] depth_max;
	logic [30:0] lock_max;
	wide_t       lever[3];
	logic [63:0] mount;

	// Shadow of the block's state.
	int          samples_seen;
	logic [47:0] prev_time;
	wide_t       prev_pos[3];

	// Scratch for the quaternion rotation.
	wide_t       rq[4];
	wide_t       rv[3];
	wide_t       ro[3];

	assign pending = velocity_q.size();

	function automatic wide_t clip32(input wide_t x);
		if (x > 80'sh7fffffff) return 80'sh7fffffff;
		if (x < -80'sh80000000) return -80'sh80000000;
		return x;
	endfunction

	function automatic wide_t round_down(input wide_t x, input int k);
		wide_t t;
		t = x + (wide_t'(1) <<< (k - 1));
		return t >>> k;
	endfunction

	// Applies the transpose of the rotation matrix of rq to rv, result in ro.
	function automatic void rotate_back();
		wide_t m[3][3];
		wide_t acc;
		m[0][0] = (wide_t'(1) <<< 28) - 2 * (rq[2] * rq[2] + rq[3] * rq[3]);
		m[0][1] = 2 * (rq[1] * rq[2] - rq[0] * rq[3]);
		m[0][2] = 2 * (rq[1] * rq[3] + rq[0] * rq[2]);
		m[1][0] = 2 * (rq[1] * rq[2] + rq[0] * rq[3]);
		m[1][1] = (wide_t'(1) <<< 28) - 2 * (rq[1] * rq[1] + rq[3] * rq[3]);
		m[1][2] = 2 * (rq[2] * rq[3] - rq[0] * rq[1]);
		m[2][0] = 2 * (rq[1] * rq[3] - rq[0] * rq[2]);
		m[2][1] = 2 * (rq[2] * rq[3] + rq[0] * rq[1]);
		m[2][2] = (wide_t'(1) <<< 28) - 2 * (rq[1] * rq[1] + rq[2] * rq[2]);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) begin
				acc += round_down(m[j][i], 8) * rv[j];
			end
			ro[i] = clip32(round_down(acc, 20));
		end
	endfunction

	// Works out the velocity record that an emitting pose sample produces.
	function automatic velocity_t pose_to_velocity();
		velocity_t   res;
		logic [47:0] dt;
		wide_t       pos[3];
		wide_t       vel[3];
		wide_t       rate[3];
		wide_t       arm[3];
		wide_t       d;
		wide_t       alt;
		logic [79:0] mag;
		logic [79:0] quo;
		pos[0] = wide_t'(pos_x);
		pos[1] = wide_t'(pos_y);
		pos[2] = wide_t'(pos_z);
		dt = time_us - prev_time;
		prev_time = time_us;
		// NED velocity from the position difference, saturated when no time has passed.
		for (int i = 0; i < 3; i++) begin
			d = pos[i] - prev_pos[i];
			prev_pos[i] = pos[i];
			if (dt == 0) begin
				vel[i] = d > 0 ? 80'sh7fffffff : (d < 0 ? -80'sh80000000 : 80'sh0);
			end else begin
				mag = (d < 0 ? -d : d) * 80'd1000000;
				quo = (mag + dt / 2) / dt;
				if (quo > (80'd1 << 32)) quo = 80'd1 << 32;
				vel[i] = clip32(d < 0 ? -wide_t'(quo) : wide_t'(quo));
			end
		end
		// Into the body frame.
		rq[0] = wide_t'(att_w);
		rq[1] = wide_t'(att_x);
		rq[2] = wide_t'(att_y);
		rq[3] = wide_t'(att_z);
		for (int i = 0; i < 3; i++) rv[i] = vel[i];
		rotate_back();
		// Lever-arm term, added before the mount rotation.
		rate[0] = wide_t'(rate_p);
		rate[1] = wide_t'(rate_q);
		rate[2] = wide_t'(rate_r);
		arm[0] = clip32(round_down(rate[1] * lever[2] - rate[2] * lever[1], FRAC_BITS));
		arm[1] = clip32(round_down(rate[2] * lever[0] - rate[0] * lever[2], FRAC_BITS));
		arm[2] = clip32(round_down(rate[0] * lever[1] - rate[1] * lever[0], FRAC_BITS));
		for (int i = 0; i < 3; i++) rv[i] = clip32(ro[i] + arm[i]);
		for (int i = 0; i < 4; i++) rq[i] = wide_t'($signed(mount[63 - 16 * i -: 16]));
		rotate_back();
		alt = wide_t'(depth_max) - pos[2];
		res.vx = vel[0][31:0];
		res.vy = vel[1][31:0];
		res.vz = vel[2][31:0];
		res.bu = ro[0][31:0];
		res.bv = ro[1][31:0];
		res.bw = ro[2][31:0];
		res.lock = alt < wide_t'(lock_max);
		alt = clip32(alt);
		res.alt = res.lock ? alt[31:0] : '0;
		return res;
	endfunction

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
		fail_count++;
	endtask

	// Watches the configuration port and both channels at each clock edge.
	always @(posedge clk or negedge arst_n) begin
		velocity_t want;
		int        dec;
		if (!arst_n) begin
			velocity_q.delete();
			fail_count = 0;
			decim = 8'd1;
			depth_max = 31'd6553600;
			lock_max = 31'd6553600;
			for (int i = 0; i < 3; i++) begin
				lever[i] = '0;
				prev_pos[i] = '0;
			end
			mount = 64'h4000_0000_0000_0000;
			samples_seen = 0;
			prev_time = '0;
		end else begin
			// Register writes.
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[5:3]))
					REG_DECIMATION: decim = pwdata[7:0];
					REG_MAX_DEPTH:  depth_max = pwdata[30:0];
					REG_MAX_LOCK:   lock_max = pwdata[30:0];
					REG_LEVER_X:    lever[0] = wide_t'($signed(pwdata[31:0]));
					REG_LEVER_Y:    lever[1] = wide_t'($signed(pwdata[31:0]));
					REG_LEVER_Z:    lever[2] = wide_t'($signed(pwdata[31:0]));
					REG_MOUNT_QUAT: mount = pwdata;
					default: ;
				endcase
			end
			// Output transaction against the oldest expectation.
			if (out_valid && !out_stall) begin
				if (velocity_q.size() == 0) begin
					$display("%0t: velocity output with none expected", $realtime);
					fail_count++;
				end else begin
					want = velocity_q.pop_front();
					if (ned_vx !== want.vx) report("ned_vx", ned_vx, want.vx);
					if (ned_vy !== want.vy) report("ned_vy", ned_vy, want.vy);
					if (ned_vz !== want.vz) report("ned_vz", ned_vz, want.vz);
					if (body_u !== want.bu) report("body_u", body_u, want.bu);
					if (body_v !== want.bv) report("body_v", body_v, want.bv);
					if (body_w !== want.bw) report("body_w", body_w, want.bw);
					if (altitude !== want.alt) report("altitude", altitude, want.alt);
					if (bottom_lock !== want.lock) begin
						report("bottom_lock", 32'(bottom_lock), 32'(want.lock));
					end
				end
			end
			// Input transaction: count it and predict when it emits.
			if (in_valid && !in_stall) begin
				dec = (decim == 0) ? 1 : int'(decim);
				if (samples_seen + 1 < dec) begin
					samples_seen++;
				end else begin
					samples_seen = 0;
					velocity_q.push_back(pose_to_velocity());
				end
			end
		end
	end

endmodule

/* dv/tb_dvl_body_velocity_from_pose_top.sv */
`timescale 1ns / 100ps
// Testbench top for the pose-to-velocity block: stimulus, configuration and verdict.
module tb_dvl_body_velocity_from_pose_top;
	import dvlbv_pkg::*;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [CFG_AW-1:0]         paddr;
	logic [CFG_DW-1:0]         pwdata;
	logic [CFG_DW-1:0]         prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_stall;
	logic [TIME_W-1:0]         time_us;
	logic signed [DATA_W-1:0]  pos_x;
	logic signed [DATA_W-1:0]  pos_y;
	logic signed [DATA_W-1:0]  pos_z;
	logic signed [QUAT_W-1:0]  att_w;
	logic signed [QUAT_W-1:0]  att_x;
	logic signed [QUAT_W-1:0]  att_y;
	logic signed [QUAT_W-1:0]  att_z;
	logic signed [DATA_W-1:0]  rate_p;
	logic signed [DATA_W-1:0]  rate_q;
	logic signed [DATA_W-1:0]  rate_r;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [DATA_W-1:0]  ned_vx;
	logic signed [DATA_W-1:0]  ned_vy;
	logic signed [DATA_W-1:0]  ned_vz;
	logic signed [DATA_W-1:0]  body_u;
	logic signed [DATA_W-1:0]  body_v;
	logic signed [DATA_W-1:0]  body_w;
	logic signed [DATA_W-1:0]  altitude;
	logic                      bottom_lock;
	int                        fail_count;
	int                        pending;

	int                        send_idle;
	int                        recv_idle;
	logic [47:0]               clock_us;
	logic signed [31:0]        track[3];

	dvl_body_velocity_from_pose_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .time_us(time_us),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.att_w(att_w), .att_x(att_x), .att_y(att_y), .att_z(att_z),
		.rate_p(rate_p), .rate_q(rate_q), .rate_r(rate_r),
		.out_valid(out_valid), .out_stall(out_stall),
		.ned_vx(ned_vx), .ned_vy(ned_vy), .ned_vz(ned_vz),
		.body_u(body_u), .body_v(body_v), .body_w(body_w),
		.altitude(altitude), .bottom_lock(bottom_lock)
	);

	dvl_body_velocity_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .time_us(time_us),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.att_w(att_w), .att_x(att_x), .att_y(att_y), .att_z(att_z),
		.rate_p(rate_p), .rate_q(rate_q), .rate_r(rate_r),
		.out_valid(out_valid), .out_stall(out_stall),
		.ned_vx(ned_vx), .ned_vy(ned_vy), .ned_vz(ned_vz),
		.body_u(body_u), .body_v(body_v), .body_w(body_w),
		.altitude(altitude), .bottom_lock(bottom_lock),
		.fail_count(fail_count), .pending(pending)
	);

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The receiver stalls at random, at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	// Hard limit on the run.
	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Single APB write: setup cycle, then access cycle.
	task automatic reg_write(input reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= CFG_AW'(idx) << 3;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every expected velocity has come out and the block has gone quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Offers one pose sample, after an optional gap, and holds it until taken.
	task automatic send_pose(input logic [47:0] t, input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz, input logic [63:0] att, input logic [31:0] rp,
			input logic [31:0] rq, input logic [31:0] rr);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		time_us <= t;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		{att_w, att_x, att_y, att_z} <= att;
		rate_p <= rp;
		rate_q <= rq;
		rate_r <= rr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// A 32-bit value that favours the extremes and small magnitudes.
	function automatic logic [31:0] any32();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	// An attitude quaternion: mostly near unit, sometimes anything at all.
	function automatic logic [63:0] any_quat();
		logic [63:0] q;
		if ($urandom_range(0, 2) == 0) begin
			q = {$urandom, $urandom};
		end else begin
			for (int i = 0; i < 4; i++) begin
				q[16 * i +: 16] = 16'($signed($urandom_range(0, 16384)) - 8192);
			end
			q[63:48] = 16'sd16384 - 16'($urandom_range(0, 4000));
		end
		return q;
	endfunction

	// A random but mostly plausible pose track, with jumps, repeats and backward steps.
	task automatic random_poses(input int count);
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 19))
				0: ;
				1: clock_us = 48'({$urandom, $urandom});
				2: clock_us = clock_us - 48'($urandom_range(1, 1000));
				default: clock_us = clock_us + 48'($urandom_range(1, 200000));
			endcase
			for (int i = 0; i < 3; i++) begin
				if ($urandom_range(0, 9) == 0) track[i] = any32();
				else track[i] = track[i] + 32'($signed($urandom_range(0, 200000)) - 100000);
			end
			send_pose(clock_us, track[0], track[1], track[2], any_quat(), any32(), any32(),
				any32());
		end
	endtask

	// Writes a complete register setting.
	task automatic configure(input logic [7:0] dec, input logic [30:0] depth,
			input logic [30:0] lock, input logic [31:0] lx, input logic [31:0] ly,
			input logic [31:0] lz, input logic [63:0] mq);
		reg_write(REG_DECIMATION, 64'(dec));
		reg_write(REG_MAX_DEPTH, 64'(depth));
		reg_write(REG_MAX_LOCK, 64'(lock));
		reg_write(REG_LEVER_X, 64'(lx));
		reg_write(REG_LEVER_Y, 64'(ly));
		reg_write(REG_LEVER_Z, 64'(lz));
		reg_write(REG_MOUNT_QUAT, mq);
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		time_us = '0;
		{pos_x, pos_y, pos_z} = '0;
		{att_w, att_x, att_y, att_z} = '0;
		{rate_p, rate_q, rate_r} = '0;
		send_idle = 12;
		recv_idle = 66;
		clock_us = '0;
		for (int i = 0; i < 3; i++) track[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero elapsed time, saturation, wrap-around and extreme operands.
		configure(8'd1, 31'd6553600, 31'd6553600, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 64'h4000_0000_0000_0000);
		send_pose(48'd0, 32'd0, 32'd0, 32'd0, 64'h4000_0000_0000_0000, 32'd0, 32'd0, 32'd0);
		send_pose(48'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 64'h7fff_8000_7fff_8000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_pose(48'd1, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 64'h8000_8000_8000_8000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pose(48'd1000001, 32'd65536, 32'hffff_0000, 32'h0640_0000, 64'h0,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_pose(48'd5, 32'd65537, 32'hfffe_ffff, 32'h063f_ffff, 64'h7fff_7fff_7fff_7fff,
			32'd1, 32'hffff_ffff, 32'd0);
		send_pose(48'hffff_ffff_ffff, 32'd3, 32'd2, 32'h7fff_ffff, 64'h2d41_2d41_0000_0000,
			32'h0001_0000, 32'h0, 32'hffff_0000);
		send_pose(48'd0, 32'd2, 32'd1, 32'h8000_0000, 64'hc000_0000_0000_0000,
			32'h0, 32'h0001_0000, 32'h0);
		send_pose(48'd2, 32'd1, 32'd1, 32'h0640_0000, 64'h0000_4000_0000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_pose(48'd3, 32'd1, 32'd1, 32'h063f_ffff, 64'h0000_0000_4000_0000,
			32'h1234_5678, 32'hedcb_a988, 32'h0000_8000);
		send_pose(48'd3000003, 32'h0012_0000, 32'hffee_0000, 32'h0000_8000,
			64'h0000_0000_0000_4000, 32'h0000_8000, 32'hffff_8000, 32'h0000_7fff);
		drain();

		// Widest ranges with every sample emitting, then decimation by three; sender idles a little, receiver a lot.
		configure(8'd1, 31'h7fff_ffff, 31'h7fff_ffff, any32(), any32(), any32(),
			{$urandom, $urandom});
		random_poses(300);
		drain();
		configure(8'd3, 31'd0, 31'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000,
			any_quat());
		random_poses(150);
		drain();

		// Receiver idles a little, sender a lot.
		send_idle = 66;
		recv_idle = 12;
		configure(8'd2, 31'($urandom), 31'($urandom), any32(), any32(), any32(), any_quat());
		random_poses(250);
		drain();
		// Leave the counter well above the next setting, so the next sample emits at once.
		configure(8'd255, 31'd6553600, 31'h0100_0000, any32(), any32(), any32(), any_quat());
		random_poses(80);
		drain();
		reg_write(REG_DECIMATION, 64'd2);

		// No idling at all, including the zero decimation setting.
		send_idle = 0;
		recv_idle = 0;
		random_poses(150);
		drain();
		configure(8'd0, 31'd13107200, 31'd6553600, any32(), any32(), any32(),
			{$urandom, $urandom});
		random_poses(300);

		drain();
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
